// ----- rtl/elevator_group_dispatcher_defines.svh -----
// assertion macros shared by the dispatcher rtl
`ifndef ELEVATOR_GROUP_DISPATCHER_DEFINES_SVH
`define ELEVATOR_GROUP_DISPATCHER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define EGD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error("dispatcher check failed");

// next-cycle implication, checked outside reset
`define EGD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error("dispatcher check failed");

`endif

// ----- rtl/egd_pkg.sv -----
// types and constants of the elevator group dispatcher
`default_nettype none
package egd_pkg;

	localparam int NUM_CARS_DEF   = 4;
	localparam int NUM_FLOORS_DEF = 16;
	localparam int FLOOR_W        = 4;

	// operation codes
	typedef enum logic [1:0] {
		OP_HALL   = 2'd0,
		OP_STATUS = 2'd1,
		OP_SERVED = 2'd2
	} op_t;

	// dispatch strategies
	typedef enum logic [1:0] {
		STRAT_DIRECTED = 2'd0,
		STRAT_NEAREST  = 2'd1,
		STRAT_SKIP     = 2'd2
	} strategy_t;

	// heading codes
	localparam logic [1:0] HEAD_IDLE = 2'd0;
	localparam logic [1:0] HEAD_UP   = 2'd1;
	localparam logic [1:0] HEAD_DOWN = 2'd2;

	typedef struct packed {
		logic [1:0]         operation;
		logic [FLOOR_W-1:0] floor;
		logic [1:0]         car;
		logic [1:0]         heading;
	} req_item_t;

	typedef struct packed {
		logic       assigned;
		logic [1:0] chosen_car;
		logic       already_routed;
	} rsp_item_t;

	// running search record passed from cell to cell
	typedef struct packed {
		logic               valid;
		logic               routed;
		logic               has_best;
		logic [FLOOR_W-1:0] best_d;
		logic               dir_valid;
	} rec_t;

	// state update broadcast to all cells
	typedef struct packed {
		logic               set_en;
		logic               clr_en;
		logic               stat_en;
		logic [FLOOR_W-1:0] floor;
		logic [1:0]         heading;
	} upd_t;

endpackage
`default_nettype wire

// ----- rtl/egd_cell.sv -----
// one car cell: holds floor, heading and pending bitmap, joins the search chain
`default_nettype none
module egd_cell #(
	parameter int NUM_FLOORS = egd_pkg::NUM_FLOORS_DEF,
	parameter int IDX_W      = 2,
	parameter int IDX        = 0
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire [egd_pkg::FLOOR_W-1:0]  floor_req,
	input  egd_pkg::rec_t               rec_in,
	input  wire [IDX_W-1:0]             first_in,
	input  wire [IDX_W-1:0]             dir_in,
	output egd_pkg::rec_t               rec_out,
	output logic [IDX_W-1:0]            first_out,
	output logic [IDX_W-1:0]            dir_out,
	input  egd_pkg::upd_t               upd,
	input  wire                         sel
);

	logic [egd_pkg::FLOOR_W-1:0] car_floor_q;
	logic [1:0]                  car_heading_q;
	logic [NUM_FLOORS-1:0]       pending_q;

	egd_pkg::rec_t               rec_q;
	egd_pkg::rec_t               rec_d;
	logic [IDX_W-1:0]            first_q, dir_q, first_d, dir_d;

	logic [NUM_FLOORS-1:0]       mask_req, mask_upd;
	logic [egd_pkg::FLOOR_W-1:0] car_gap;
	logic                        toward;

	assign mask_req = NUM_FLOORS'(1) << floor_req;
	assign mask_upd = NUM_FLOORS'(1) << upd.floor;

	// distance and heading of this car toward the requested floor
	assign car_gap = (floor_req > car_floor_q) ? (floor_req - car_floor_q)
	                                           : (car_floor_q - floor_req);
	assign toward = ((floor_req > car_floor_q) && (car_heading_q == egd_pkg::HEAD_UP)) ||
	                ((floor_req < car_floor_q) && (car_heading_q == egd_pkg::HEAD_DOWN));

	// fold this car into the running record
	always_comb begin
		rec_d   = rec_in;
		first_d = first_in;
		dir_d   = dir_in;
		rec_d.routed = rec_in.routed | (|(pending_q & mask_req));
		if (!rec_in.has_best || (car_gap < rec_in.best_d)) begin
			rec_d.has_best  = 1'b1;
			rec_d.best_d    = car_gap;
			rec_d.dir_valid = toward;
			first_d         = IDX_W'(IDX);
			dir_d           = IDX_W'(IDX);
		end else if ((car_gap == rec_in.best_d) && !rec_in.dir_valid && toward) begin
			rec_d.dir_valid = 1'b1;
			dir_d           = IDX_W'(IDX);
		end
	end

	// car state and chain register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			car_floor_q   <= egd_pkg::FLOOR_W'(1);
			car_heading_q <= egd_pkg::HEAD_IDLE;
			pending_q     <= '0;
			rec_q         <= '0;
		end else begin
			rec_q <= rec_d;
			if (sel && upd.stat_en) begin
				car_floor_q   <= upd.floor;
				car_heading_q <= upd.heading;
			end
			if (sel && upd.set_en) begin
				pending_q <= pending_q | mask_upd;
			end else if (sel && upd.clr_en) begin
				pending_q <= pending_q & ~mask_upd;
			end
		end
	end

	// index payload of the chain register
	always_ff @(posedge clk) begin
		first_q <= first_d;
		dir_q   <= dir_d;
	end

	assign rec_out   = rec_q;
	assign first_out = first_q;
	assign dir_out   = dir_q;

endmodule
`default_nettype wire

// ----- rtl/elevator_group_dispatcher.sv -----
// elevator group dispatcher top level: control, strategy register, car cell chain
//
//   channel   | handshake             | payload
//   ----------+-----------------------+-----------------------------
//   request   | req_valid / req_stall | req (operation floor car heading)
//   response  | rsp_valid / rsp_stall | rsp (assigned chosen_car already_routed)
//   config    | strategy_we           | strategy_data
//
// a hall request walks the chain one car cell per cycle: accept sets the start flag,
// each car cell registers the record, then come the finish step and the output register.
// status, served and ignored items go straight to the finish step and output register.
// reset sets every car to floor 1, idle, nothing pending, strategy direction-aware.
// req_stall is high while an item is in work; a stalled response holds the
// item in the finish step until the output register frees.
`default_nettype none
`include "elevator_group_dispatcher_defines.svh"
module elevator_group_dispatcher #(
	parameter int NUM_CARS   = egd_pkg::NUM_CARS_DEF,
	parameter int NUM_FLOORS = egd_pkg::NUM_FLOORS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_stall,
	input  egd_pkg::req_item_t req,
	output logic               rsp_valid,
	input  wire                rsp_stall,
	output egd_pkg::rsp_item_t rsp,
	input  wire                strategy_we,
	input  wire [1:0]          strategy_data
);

	localparam int IW = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t               state_q;
	egd_pkg::strategy_t   strategy_q;
	egd_pkg::req_item_t   item_q;
	egd_pkg::rsp_item_t   res_q, rsp_q, rsp_d;
	logic [IW-1:0]        chosen_q, chosen_d;
	logic                 start_q, rsp_valid_q;

	egd_pkg::rec_t        rec_chain   [NUM_CARS+1];
	logic [IW-1:0]        first_chain [NUM_CARS+1];
	logic [IW-1:0]        dir_chain   [NUM_CARS+1];

	egd_pkg::upd_t        upd;
	logic [NUM_CARS-1:0]  sel;
	logic                 in_take, out_free, floor_ok, car_ok, commit, is_hall;
	logic                 tail_routed, tail_assigned;
	logic [31:0]          chosen_wide;

	assign in_take  = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign commit   = (state_q == ST_FINISH) && out_free;
	assign floor_ok = 32'(item_q.floor) < NUM_FLOORS;
	assign car_ok   = 32'(item_q.car) < NUM_CARS;
	assign is_hall  = item_q.operation == egd_pkg::OP_HALL;

	// strategy register, reserved code ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_q <= egd_pkg::STRAT_DIRECTED;
		end else if (strategy_we && (strategy_data == egd_pkg::STRAT_DIRECTED ||
		             strategy_data == egd_pkg::STRAT_NEAREST ||
		             strategy_data == egd_pkg::STRAT_SKIP)) begin
			strategy_q <= egd_pkg::strategy_t'(strategy_data);
		end
	end

	// head of the search chain
	always_comb begin
		rec_chain[0]       = '0;
		rec_chain[0].valid = start_q;
		first_chain[0]     = '0;
		dir_chain[0]       = '0;
	end

	// row of car cells
	for (genvar i = 0; i < NUM_CARS; i++) begin : g_cell
		egd_cell #(
			.NUM_FLOORS (NUM_FLOORS),
			.IDX_W      (IW),
			.IDX        (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.floor_req (item_q.floor),
			.rec_in    (rec_chain[i]),
			.first_in  (first_chain[i]),
			.dir_in    (dir_chain[i]),
			.rec_out   (rec_chain[i+1]),
			.first_out (first_chain[i+1]),
			.dir_out   (dir_chain[i+1]),
			.upd       (upd),
			.sel       (sel[i])
		);
	end

	// pick the car from the record at the tail of the chain
	always_comb begin
		tail_routed   = rec_chain[NUM_CARS].routed;
		tail_assigned = !((strategy_q == egd_pkg::STRAT_SKIP) && tail_routed);
		if ((strategy_q != egd_pkg::STRAT_NEAREST) && rec_chain[NUM_CARS].dir_valid) begin
			chosen_d = dir_chain[NUM_CARS];
		end else begin
			chosen_d = first_chain[NUM_CARS];
		end
	end

	// state update sent to the cells on commit
	always_comb begin
		upd.floor   = item_q.floor;
		upd.heading = item_q.heading;
		upd.set_en  = commit && is_hall && res_q.assigned;
		upd.clr_en  = commit && (item_q.operation == egd_pkg::OP_SERVED) && car_ok && floor_ok;
		upd.stat_en = commit && (item_q.operation == egd_pkg::OP_STATUS) && car_ok && floor_ok;
		for (int i = 0; i < NUM_CARS; i++) begin
			sel[i] = is_hall ? (32'(chosen_q) == i) : (32'(item_q.car) == i);
		end
	end

	assign chosen_wide = 32'(chosen_q);

	// control sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if ((req.operation == egd_pkg::OP_HALL) &&
						    (32'(req.floor) < NUM_FLOORS)) begin
							start_q <= 1'b1;
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_SCAN: begin
					if (rec_chain[NUM_CARS].valid) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_q   <= req;
			res_q    <= '0;
			chosen_q <= '0;
		end else if ((state_q == ST_SCAN) && rec_chain[NUM_CARS].valid) begin
			res_q    <= {tail_assigned, 2'b00, tail_routed};
			chosen_q <= tail_assigned ? chosen_d : '0;
		end
	end

	// response with the chosen car filled in
	always_comb begin
		rsp_d            = res_q;
		rsp_d.chosen_car = chosen_wide[1:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign req_stall = state_q != ST_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	`EGD_ASSERT_IMP(a_scan_len, start_q, ##NUM_CARS rec_chain[NUM_CARS].valid)
	`EGD_ASSERT_IMP(a_tail_in_scan, rec_chain[NUM_CARS].valid, state_q == ST_SCAN)
	`EGD_ASSERT_NXT(a_commit_out, commit, (state_q == ST_IDLE) && rsp_valid)
	`EGD_ASSERT_IMP(a_none_zero, rsp_valid && !rsp.assigned, rsp.chosen_car == 2'd0)

endmodule
`default_nettype wire
